@@ rtl/packed_asset_container_deframer_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the container deframer
// Shared concurrent assertion wrappers; they compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef PACKED_ASSET_CONTAINER_DEFRAMER_DEFINES_SVH
`define PACKED_ASSET_CONTAINER_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// checked only outside reset
`define PACD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked in every cycle, reset included
`define PACD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PACD_ASSERT(lbl, prop, msg)
`define PACD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/pacd_pkg.sv @@
// ---------------------------------------------------------------------------
// pacd_pkg
// Types, phase codes and the magic table of the container deframer.
// ---------------------------------------------------------------------------
package pacd_pkg;

  localparam int QUEUE_DEPTH = 2;

  // parse phase, also the byte class that the phase gives
  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_FLAGS   = 4'd1,
    PH_HDR     = 4'd2,
    PH_NAME    = 4'd3,
    PH_PAD     = 4'd4,
    PH_AUDIO   = 4'd5,
    PH_SIZE    = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_REJECT  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  localparam logic [3:0] MAGIC_LEN  = 4'd12;
  localparam logic [6:0] KIND_AUDIO = 7'd5;

  // one input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [3:0]  byte_class;
    logic [6:0]  entry_kind;
    logic        entry_compressed;
    logic [23:0] payload_length;
    logic [23:0] sample_rate;
    logic [7:0]  audio_format_code;
    logic [31:0] uncompressed_size;
    logic        entry_done;
    logic [1:0]  parse_status;
  } result_t;

  // file magic, one byte per index
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h50;
      4'd1:    b = 8'h6C;
      4'd2:    b = 8'h61;
      4'd3:    b = 8'h79;
      4'd4:    b = 8'h64;
      4'd5:    b = 8'h61;
      4'd6:    b = 8'h74;
      4'd7:    b = 8'h65;
      4'd8:    b = 8'h20;
      4'd9:    b = 8'h50;
      4'd10:   b = 8'h44;
      4'd11:   b = 8'h5A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/pacd_if.sv @@
// ---------------------------------------------------------------------------
// pacd_in_if / pacd_out_if
// Valid/ready channels of the deframer.
// ---------------------------------------------------------------------------
interface pacd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;
  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface pacd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [3:0]  byte_class;
  logic [6:0]  entry_kind;
  logic        entry_compressed;
  logic [23:0] payload_length;
  logic [23:0] sample_rate;
  logic [7:0]  audio_format_code;
  logic [31:0] uncompressed_size;
  logic        entry_done;
  logic [1:0]  parse_status;
  modport source (output valid, output out_byte, output byte_class, output entry_kind,
                  output entry_compressed, output payload_length, output sample_rate,
                  output audio_format_code, output uncompressed_size, output entry_done,
                  output parse_status, input ready);
  modport sink (input valid, input out_byte, input byte_class, input entry_kind,
                input entry_compressed, input payload_length, input sample_rate,
                input audio_format_code, input uncompressed_size, input entry_done,
                input parse_status, output ready);
endinterface

@@ rtl/pacd_queue.sv @@
// ---------------------------------------------------------------------------
// pacd_queue
// Front side: takes input beats into a short queue ahead of the parser.
// ---------------------------------------------------------------------------
`include "packed_asset_container_deframer_defines.svh"

module pacd_queue #(
  parameter int DEPTH = pacd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  pacd_in_if.sink        in_ch,
  output logic           deq_valid,
  output pacd_pkg::beat_t deq_beat,
  input  logic           deq_ready
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  pacd_pkg::beat_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic push;
  logic pop;

  assign in_ch.ready = (count != FULL);
  assign push = in_ch.valid && in_ch.ready;
  assign deq_valid = (count != '0);
  assign pop = deq_valid && deq_ready;
  assign deq_beat = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{in_byte: in_ch.in_byte, end_of_file: in_ch.end_of_file};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `PACD_ASSERT(a_count_max, count <= FULL, "queue count above depth")
  `PACD_ASSERT(a_count_step, (push && !pop) |=> count == $past(count) + 1'b1,
               "queue count missed a push")
  `PACD_ASSERT(a_empty_ptrs, (count == '0) |-> (wr_ptr == rd_ptr),
               "queue pointers differ while empty")
endmodule

@@ rtl/pacd_parser.sv @@
// ---------------------------------------------------------------------------
// pacd_parser
// Back side: walks the container one beat a cycle while the output is not stalled, and registers results.
// ---------------------------------------------------------------------------
`include "packed_asset_container_deframer_defines.svh"

module pacd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            deq_valid,
  input  pacd_pkg::beat_t deq_beat,
  output logic            deq_ready,
  pacd_out_if.source      out_ch
);
  pacd_pkg::phase_t ph, ph_next;
  logic [1:0]  ofs, ofs_next;
  logic [3:0]  cnt, cnt_next;
  logic [23:0] len, len_next;
  logic [6:0]  kind, kind_next;
  logic        comp, comp_next;
  logic [23:0] rate, rate_next;
  logic [7:0]  fmt, fmt_next;
  logic [31:0] size, size_next;
  logic [23:0] left, left_next;
  logic        rte, rte_next;

  logic             ovalid;
  pacd_pkg::result_t res, res_next;
  logic             take;

  assign deq_ready = !ovalid || out_ch.ready;
  assign take = deq_valid && deq_ready;

  // next state and result for the beat at the head of the queue
  always_comb begin
    logic [7:0] b;
    logic       eof;
    logic [3:0] cls;
    logic [1:0] st;
    logic       done;
    logic       zero_audio;
    logic       to_pad;
    logic       to_audio;
    logic       to_begin;
    logic       dropped;
    b = deq_beat.in_byte;
    eof = deq_beat.end_of_file;
    ph_next = ph;
    ofs_next = ofs + 2'd1;
    cnt_next = cnt;
    len_next = len;
    kind_next = kind;
    comp_next = comp;
    rate_next = rate;
    fmt_next = fmt;
    size_next = size;
    left_next = left;
    rte_next = rte;
    cls = 4'(pacd_pkg::PH_REJECT);
    st = pacd_pkg::ST_OK;
    done = 1'b0;
    zero_audio = 1'b0;
    to_pad = 1'b0;
    to_audio = 1'b0;
    to_begin = 1'b0;
    dropped = 1'b0;

    unique case (ph)
      pacd_pkg::PH_MAGIC: begin
        cls = 4'(pacd_pkg::PH_MAGIC);
        cnt_next = cnt + 4'd1;
        if (b != pacd_pkg::magic_byte(cnt)) begin
          ph_next = pacd_pkg::PH_REJECT;
          st = pacd_pkg::ST_BAD;
        end else if (cnt_next >= pacd_pkg::MAGIC_LEN) begin
          ph_next = pacd_pkg::PH_FLAGS;
          cnt_next = '0;
        end
        if (eof) st = pacd_pkg::ST_BAD;
      end
      pacd_pkg::PH_FLAGS: begin
        cls = 4'(pacd_pkg::PH_FLAGS);
        cnt_next = cnt + 4'd1;
        if (cnt_next >= 4'd4) begin
          ph_next = pacd_pkg::PH_HDR;
          cnt_next = '0;
        end else if (eof) begin
          st = pacd_pkg::ST_BAD;
        end
      end
      pacd_pkg::PH_HDR: begin
        cls = 4'(pacd_pkg::PH_HDR);
        unique case (cnt[1:0])
          2'd0: begin
            kind_next = b[6:0];
            comp_next = b[7];
            len_next = '0;
            rate_next = '0;
            fmt_next = '0;
            size_next = '0;
            left_next = '0;
            rte_next = 1'b0;
          end
          2'd1: len_next[7:0] = b;
          2'd2: len_next[15:8] = b;
          default: len_next[23:16] = b;
        endcase
        cnt_next = cnt + 4'd1;
        if (cnt_next >= 4'd4) ph_next = pacd_pkg::PH_NAME;
      end
      pacd_pkg::PH_NAME: begin
        if (b != 8'd0) begin
          cls = 4'(pacd_pkg::PH_NAME);
        end else begin
          cls = 4'(pacd_pkg::PH_PAD);
          if (ofs_next == 2'd0) to_pad = 1'b1;
          else ph_next = pacd_pkg::PH_PAD;
        end
      end
      pacd_pkg::PH_PAD: begin
        cls = 4'(pacd_pkg::PH_PAD);
        if (ofs_next == 2'd0) to_pad = 1'b1;
      end
      pacd_pkg::PH_AUDIO: begin
        cls = 4'(pacd_pkg::PH_AUDIO);
        unique case (cnt[1:0])
          2'd0: rate_next[7:0] = b;
          2'd1: rate_next[15:8] = b;
          2'd2: rate_next[23:16] = b;
          default: fmt_next = b;
        endcase
        cnt_next = cnt + 4'd1;
        if (cnt_next >= 4'd4) begin
          if (len >= 24'd4) len_next = len - 24'd4;
          to_audio = 1'b1;
        end
      end
      pacd_pkg::PH_SIZE: begin
        cls = 4'(pacd_pkg::PH_SIZE);
        unique case (cnt[1:0])
          2'd0: size_next[7:0] = b;
          2'd1: size_next[15:8] = b;
          2'd2: size_next[23:16] = b;
          default: size_next[31:24] = b;
        endcase
        cnt_next = cnt + 4'd1;
        if (cnt_next >= 4'd4) begin
          if (len >= 24'd4) begin
            len_next = len - 24'd4;
          end else begin
            len_next = '0;
            rte_next = 1'b1;
          end
          to_begin = 1'b1;
        end
      end
      pacd_pkg::PH_PAYLOAD: begin
        cls = 4'(pacd_pkg::PH_PAYLOAD);
        if (!rte) begin
          if (left != '0) left_next = left - 24'd1;
          if (left_next == '0) begin
            done = 1'b1;
            ph_next = pacd_pkg::PH_HDR;
            cnt_next = '0;
          end
        end
      end
      default: begin
        st = pacd_pkg::ST_BAD;
        ph_next = pacd_pkg::PH_REJECT;
      end
    endcase

    // entry tail: pad end, audio header, size field, payload start
    if (to_pad) begin
      if (kind == pacd_pkg::KIND_AUDIO) begin
        ph_next = pacd_pkg::PH_AUDIO;
        cnt_next = '0;
      end else begin
        to_audio = 1'b1;
      end
    end
    if (to_audio) begin
      if (comp) begin
        ph_next = pacd_pkg::PH_SIZE;
        cnt_next = '0;
      end else begin
        to_begin = 1'b1;
      end
    end
    if (to_begin) begin
      if (rte_next) begin
        ph_next = pacd_pkg::PH_PAYLOAD;
      end else begin
        left_next = len_next;
        if (len_next == '0) begin
          ph_next = pacd_pkg::PH_HDR;
          cnt_next = '0;
          done = 1'b1;
        end else begin
          ph_next = pacd_pkg::PH_PAYLOAD;
        end
      end
    end

    // file ends inside an entry
    if (eof && ph >= pacd_pkg::PH_HDR && ph <= pacd_pkg::PH_PAYLOAD && !done) begin
      zero_audio = (ph_next == pacd_pkg::PH_AUDIO);
      dropped = (ph_next == pacd_pkg::PH_HDR) ||
                (comp_next && ph_next >= pacd_pkg::PH_NAME && ph_next <= pacd_pkg::PH_SIZE);
      if (dropped) st = pacd_pkg::ST_DROPPED;
      else done = 1'b1;
    end

    res_next.out_byte = b;
    res_next.byte_class = cls;
    res_next.entry_kind = kind_next;
    res_next.entry_compressed = comp_next;
    res_next.payload_length = len_next;
    res_next.sample_rate = zero_audio ? '0 : rate_next;
    res_next.audio_format_code = zero_audio ? '0 : fmt_next;
    res_next.uncompressed_size = size_next;
    res_next.entry_done = done;
    res_next.parse_status = st;
  end

  // parse state; end of file returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (take && deq_beat.end_of_file)) begin
      ph <= pacd_pkg::PH_MAGIC;
      ofs <= '0;
      cnt <= '0;
      len <= '0;
      kind <= '0;
      comp <= 1'b0;
      rate <= '0;
      fmt <= '0;
      size <= '0;
      left <= '0;
      rte <= 1'b0;
    end else if (take) begin
      ph <= ph_next;
      ofs <= ofs_next;
      cnt <= cnt_next;
      len <= len_next;
      kind <= kind_next;
      comp <= comp_next;
      rate <= rate_next;
      fmt <= fmt_next;
      size <= size_next;
      left <= left_next;
      rte <= rte_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (take) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

  assign out_ch.valid = ovalid;
  assign out_ch.out_byte = res.out_byte;
  assign out_ch.byte_class = res.byte_class;
  assign out_ch.entry_kind = res.entry_kind;
  assign out_ch.entry_compressed = res.entry_compressed;
  assign out_ch.payload_length = res.payload_length;
  assign out_ch.sample_rate = res.sample_rate;
  assign out_ch.audio_format_code = res.audio_format_code;
  assign out_ch.uncompressed_size = res.uncompressed_size;
  assign out_ch.entry_done = res.entry_done;
  assign out_ch.parse_status = res.parse_status;

  `PACD_ASSERT(a_eof_restart, (take && deq_beat.end_of_file) |=>
               (ph == pacd_pkg::PH_MAGIC && ofs == 2'd0 && cnt == 4'd0),
               "parser did not restart after end of file")
  `PACD_ASSERT(a_rte_comp, rte |-> comp, "run to end set on an uncompressed entry")
  `PACD_ASSERT(a_done_class, (ovalid && res.entry_done) |->
               (res.byte_class >= 4'd2 && res.byte_class <= 4'd7),
               "entry end marked outside an entry")
endmodule

@@ rtl/packed_asset_container_deframer.sv @@
// ---------------------------------------------------------------------------
// packed_asset_container_deframer
// Splits an asset container byte stream into tagged, classified beats.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one file byte per beat with end_of_file on the last byte.
//   out_ch returns one result beat per input beat, in order: the byte, its
//   class, the current entry's fields, an entry end mark and a status.
//   The input queue stores each accepted beat; the parser then takes it
//   and registers its result in the output register.
//   Throughput: one beat per cycle while out_ch is not stalled.
//   Reset clears the queue, the parse state and the output register; the
//   next byte is taken as the first byte of a file. The beat that carries
//   end_of_file also returns the parser to that state.
//   When the receiver stalls, the output register holds its beat and the
//   input queue fills; in_ch.ready drops once the queue is full.
// ---------------------------------------------------------------------------
module packed_asset_container_deframer #(
  parameter int QUEUE_DEPTH = pacd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  pacd_in_if.sink    in_ch,
  pacd_out_if.source out_ch
);
  logic            deq_valid;
  logic            deq_ready;
  pacd_pkg::beat_t deq_beat;

  pacd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .deq_valid (deq_valid),
    .deq_beat  (deq_beat),
    .deq_ready (deq_ready)
  );

  pacd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .deq_valid (deq_valid),
    .deq_beat  (deq_beat),
    .deq_ready (deq_ready),
    .out_ch    (out_ch)
  );
endmodule
